// File: rtl/core/assert_macros.svh
// Assertion macros shared by the polar-to-grid RTL.
// Needs a clock named clk and an active-high reset named rst in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define P2G_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define P2G_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/core/p2g_pkg.sv
// Shared types and constants for the polar-to-grid offset block.
// No dependencies; imported by every module of the block.
package p2g_pkg;

  // Angle in Q30 radians, wide enough for a bearing of +-16 rad
  typedef logic signed [35:0] angle_t;

  localparam angle_t QPi     = 36'sd3373259426;
  localparam angle_t QNegPi  = -36'sd3373259426;
  localparam angle_t QHalfPi = 36'sd1686629713;
  localparam angle_t QNegHalfPi = -36'sd1686629713;
  localparam angle_t QTwoPi  = 36'sd6746518852;

  // Folded angle in [0, pi/2], Q30
  localparam logic [30:0] FoldMax = 31'd1686629713;

  // CORDIC datapath value: cos/sin/residual angle in Q30
  typedef logic signed [32:0] cval_t;

  localparam cval_t CordicGain = 33'sd652032874;
  localparam cval_t QOne       = 33'sd1073741824;
  localparam logic [3:0] LastStep = 4'd15;

  localparam logic [7:0] PpmReset = 8'd10;

  // One classified reading handed from the front to the back
  typedef struct packed {
    logic [15:0] span;
    logic [30:0] angle;
    logic        top;
    logic        right;
  } job_t;

  // Arctangent of 2^-i in Q30, truncated
  function automatic logic [29:0] atan_q30(input logic [3:0] i);
    logic [29:0] r;
    case (i)
      4'd0:    r = 30'd843314856;
      4'd1:    r = 30'd497837829;
      4'd2:    r = 30'd263043836;
      4'd3:    r = 30'd133525158;
      4'd4:    r = 30'd67021686;
      4'd5:    r = 30'd33543515;
      4'd6:    r = 30'd16775850;
      4'd7:    r = 30'd8388437;
      4'd8:    r = 30'd4194282;
      4'd9:    r = 30'd2097149;
      4'd10:   r = 30'd1048575;
      4'd11:   r = 30'd524287;
      4'd12:   r = 30'd262143;
      4'd13:   r = 30'd131071;
      4'd14:   r = 30'd65535;
      default: r = 30'd32767;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/p2g_front.sv
// Front end: accepts a reading, wraps the bearing, picks the quadrant and
// folds the angle into [0, pi/2]. Depends on p2g_pkg.
module p2g_front import p2g_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] distance,
  input  logic signed [15:0] bearing,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);

  localparam logic [2:0] F_IDLE    = 3'd0;
  localparam logic [2:0] F_WRAP_HI = 3'd1;
  localparam logic [2:0] F_WRAP_LO = 3'd2;
  localparam logic [2:0] F_QUAD    = 3'd3;
  localparam logic [2:0] F_MOD     = 3'd4;
  localparam logic [2:0] F_PUSH    = 3'd5;

  logic [2:0]  state;
  angle_t      acc;
  logic [15:0] dist_q;
  logic        top_q;
  logic        right_q;
  angle_t      folded;

  assign in_ready  = (state == F_IDLE);
  assign job_valid = (state == F_PUSH);

  // Mirror the upper half of the half-turn down into [0, pi/2]
  always_comb begin
    folded = (acc > QHalfPi) ? (QPi - acc) : acc;
  end

  assign job.span  = dist_q;
  assign job.angle = folded[30:0];
  assign job.top   = top_q;
  assign job.right = right_q;

  // Control: one add or compare per cycle on the angle accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) state <= F_WRAP_HI;
        end
        F_WRAP_HI: state <= F_WRAP_LO;
        F_WRAP_LO: state <= F_QUAD;
        F_QUAD:    state <= F_MOD;
        F_MOD: begin
          if (!acc[35] && (acc < QPi)) state <= F_PUSH;
        end
        F_PUSH: begin
          if (job_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // Datapath: widen to Q30, wrap once, pick the quadrant, then reduce modulo pi
  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (in_valid) begin
          acc    <= {bearing[15], bearing, 19'd0};
          dist_q <= distance;
        end
      end
      F_WRAP_HI: begin
        if (acc > QPi) acc <= acc - QTwoPi;
      end
      F_WRAP_LO: begin
        if (acc < QNegPi) acc <= acc + QTwoPi;
      end
      F_QUAD: begin
        top_q   <= (acc > 36'sd0);
        right_q <= (acc > QNegHalfPi) && (acc <= QHalfPi);
      end
      F_MOD: begin
        if (acc[35]) begin
          acc <= acc + QPi;
        end else if (acc >= QPi) begin
          acc <= acc - QPi;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/core/p2g_queue.sv
// Small FIFO of classified readings between the front and the back.
// Depends on p2g_pkg for the entry type.
module p2g_queue import p2g_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  job_t            slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CntW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/p2g_back.sv
// Back end: CORDIC rotation for cos/sin, residual correction, scaling by
// the grid scale and signing by quadrant. Depends on p2g_pkg.
module p2g_back import p2g_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  input  logic [7:0]  grid_scale,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [16:0] grid_dx,
  output logic signed [16:0] grid_dy
);

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_ITER  = 3'd1;
  localparam logic [2:0] B_RES_Y = 3'd2;
  localparam logic [2:0] B_RES_X = 3'd3;
  localparam logic [2:0] B_UPD   = 3'd4;
  localparam logic [2:0] B_MAG_X = 3'd5;
  localparam logic [2:0] B_MAG_Y = 3'd6;
  localparam logic [2:0] B_EMIT  = 3'd7;

  logic [2:0]  state;
  logic [3:0]  step;
  cval_t       x;
  cval_t       y;
  cval_t       z;
  logic [23:0] mag_m;
  logic        top_q;
  logic        right_q;
  logic signed [50:0] prod_y;
  logic signed [50:0] prod_x;
  logic [30:0] cos_q;
  logic [30:0] sin_q;
  logic [16:0] xm;
  logic [16:0] ym;

  cval_t       dx;
  cval_t       dy;
  cval_t       atan_step;
  cval_t       res_sel;
  logic signed [17:0] z_res;
  logic signed [50:0] res_prod;
  logic signed [20:0] corr_y;
  logic signed [20:0] corr_x;
  cval_t       nx;
  cval_t       ny;
  logic [30:0] mag_sel;
  logic [54:0] mag_prod;
  logic        out_free;

  // Arithmetic shift right that rounds toward zero
  function automatic cval_t shr_tz(input cval_t v, input logic [3:0] n);
    cval_t       q;
    logic [32:0] mask;
    logic        lost;
    mask = (33'd1 << n) - 33'd1;
    lost = |(v & mask);
    q = v >>> n;
    if (v[32] && lost) q = q + 33'sd1;
    return q;
  endfunction

  // Drop 30 fraction bits of a residual product, rounding toward zero
  function automatic logic signed [20:0] tz30(input logic signed [50:0] p);
    logic signed [20:0] r;
    r = p[50:30];
    if (p[50] && (|p[29:0])) r = r + 21'sd1;
    return r;
  endfunction

  // Limit a cos/sin estimate to [0, 1]
  function automatic logic [30:0] clamp_unit(input cval_t v);
    logic [30:0] r;
    if (v[32]) begin
      r = '0;
    end else if (v > QOne) begin
      r = QOne[30:0];
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

  assign job_ready = (state == B_IDLE);
  assign out_free  = !out_valid || out_ready;

  // One shift-add rotation step
  always_comb begin
    dx        = shr_tz(y, step);
    dy        = shr_tz(x, step);
    atan_step = {3'd0, atan_q30(step)};
  end

  // Shared multiplier for the residual step; the final angle is small
  assign z_res    = z[17:0];
  assign res_sel  = (state == B_RES_Y) ? y : x;
  assign res_prod = 51'(res_sel) * 51'(z_res);

  always_comb begin
    corr_y = tz30(prod_y);
    corr_x = tz30(prod_x);
    nx     = x - {{12{corr_y[20]}}, corr_y};
    ny     = y + {{12{corr_x[20]}}, corr_x};
  end

  // Shared multiplier for the scaling step
  assign mag_sel  = (state == B_MAG_X) ? cos_q : sin_q;
  assign mag_prod = 55'(mag_m) * 55'(mag_sel);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      step  <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          step <= '0;
          if (job_valid) state <= B_ITER;
        end
        B_ITER: begin
          step <= step + 4'd1;
          if (step == LastStep) state <= B_RES_Y;
        end
        B_RES_Y: state <= B_RES_X;
        B_RES_X: state <= B_UPD;
        B_UPD:   state <= B_MAG_X;
        B_MAG_X: state <= B_MAG_Y;
        B_MAG_Y: state <= B_EMIT;
        B_EMIT: begin
          if (out_free) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (job_valid) begin
          x       <= CordicGain;
          y       <= '0;
          z       <= {2'd0, job.angle};
          mag_m   <= 24'(grid_scale) * 24'(job.span);
          top_q   <= job.top;
          right_q <= job.right;
        end
      end
      B_ITER: begin
        if (!z[32]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - atan_step;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + atan_step;
        end
      end
      B_RES_Y: prod_y <= res_prod;
      B_RES_X: prod_x <= res_prod;
      B_UPD: begin
        cos_q <= clamp_unit(nx);
        sin_q <= clamp_unit(ny);
      end
      B_MAG_X: xm <= mag_prod[54:38];
      B_MAG_Y: ym <= mag_prod[54:38];
      default: begin
      end
    endcase
  end

  // Output register: load a signed result, hold it until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == B_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == B_EMIT) && out_free) begin
      grid_dx <= right_q ? xm : (~xm + 17'd1);
      grid_dy <= top_q ? (~ym + 17'd1) : ym;
    end
  end

endmodule

// File: rtl/core/polar_to_grid_offset.sv
// Polar-to-grid offset: turns a range reading (Q8.8 meters, bearing in
// radians with 11 fraction bits) into a signed grid offset, x positive to the
// right and y negative toward the top. The front end takes a reading, wraps
// it once by 2*pi, picks the quadrant and folds the angle; a queue of
// QUEUE_DEPTH readings lets it run ahead of the back end. The back end sets
// the rate: it loads the job, runs 16 CORDIC iterations on one shift-add
// unit, uses the shared residual multiplier, clamps, uses the shared scaling
// multiplier and loads the output; it takes no new reading before that load.
// grid_scale resets to 10; the user is to write it through cfg_write/cfg_data
// only while the block is idle, as the block itself does not enforce this.
`include "assert_macros.svh"

module polar_to_grid_offset import p2g_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] distance,
  input  logic signed [15:0] bearing,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [16:0] grid_dx,
  output logic signed [16:0] grid_dy
);

  logic [7:0] grid_scale;
  logic       front_valid;
  logic       front_ready;
  job_t       front_job;
  logic       back_valid;
  logic       back_ready;
  job_t       back_job;
  logic       job_push;

  // Scale register
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_scale <= PpmReset;
    end else if (cfg_write) begin
      grid_scale <= cfg_data;
    end
  end

  p2g_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .distance  (distance),
    .bearing   (bearing),
    .job_valid (front_valid),
    .job_ready (front_ready),
    .job       (front_job)
  );

  p2g_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_job)
  );

  p2g_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (back_valid),
    .job_ready  (back_ready),
    .job        (back_job),
    .grid_scale (grid_scale),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .grid_dx    (grid_dx),
    .grid_dy    (grid_dy)
  );

  assign job_push = front_valid && front_ready;

  // Folded angle must land in [0, pi/2] before the CORDIC sees it
  `P2G_ASSERT_IMP(a_fold_range, job_push, front_job.angle <= FoldMax, "folded angle above pi/2")
  // Magnitudes never reach 2^16, so neither offset is the most negative code
  `P2G_ASSERT_IMP(a_dx_range, out_valid, grid_dx != 17'h10000, "grid_dx out of range")
  `P2G_ASSERT_IMP(a_dy_range, out_valid, grid_dy != 17'h10000, "grid_dy out of range")

endmodule

// File: sim/tb_polar_to_grid_offset.sv
// Testbench for polar_to_grid_offset: range readings in, signed grid offsets out.
// Needs only the block's RTL (p2g_pkg, p2g_front, p2g_queue, p2g_back and polar_to_grid_offset); predicts every
// offset with its own CORDIC model and checks each output beat in order.
`timescale 1ns / 1ps

module tb_polar_to_grid_offset;

  localparam int CycleLimit  = 600000;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 60;
  localparam int NumDirected = 24;

  // Q30 angle constants and CORDIC gain
  localparam longint AngPi     = 64'sd3373259426;
  localparam longint AngHalfPi = 64'sd1686629713;
  localparam longint AngTwoPi  = 64'sd6746518852;
  localparam longint UnitQ30   = 64'sd1073741824;
  localparam longint RotGain   = 64'sd652032874;

  typedef struct packed {
    logic signed [16:0] dx;
    logic signed [16:0] dy;
  } grid_offset_t;

  typedef struct {
    logic [15:0]        span;
    logic signed [15:0] bear;
    bit                 literal_known;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
  } directed_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [7:0]         cfg_data = 8'd0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [15:0]        distance = 16'd0;
  logic signed [15:0] bearing = 16'sd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [16:0] grid_dx;
  logic signed [16:0] grid_dy;

  grid_offset_t expected_offsets[$];
  logic [7:0]   scale_setting = 8'd10;
  int           sender_idle_pct = 0;
  int           receiver_stall_pct = 0;
  bit           hold_request = 1'b0;
  bit           hold_taken = 1'b0;
  int           hold_left = 0;
  int           readings_sent = 0;
  int           offsets_checked = 0;
  int           mismatch_count = 0;
  int           cycle_count = 0;

  // Extremes of both fields, quadrant edges, wrap edges and bearings past 3*pi
  directed_row_t directed_rows [NumDirected] = '{
    '{16'd0,     16'sd0,      1'b1, 17'sd0, 17'sd0},
    '{16'd0,     16'sd19302,  1'b1, 17'sd0, 17'sd0},
    '{16'd0,    -16'sd19302,  1'b1, 17'sd0, 17'sd0},
    '{16'd65535, 16'sd0,      1'b0, 17'sd0, 17'sd0},
    '{16'd65535, 16'sd19302,  1'b0, 17'sd0, 17'sd0},
    '{16'd65535,-16'sd19302,  1'b0, 17'sd0, 17'sd0},
    '{16'd65535, 16'sd3216,   1'b0, 17'sd0, 17'sd0},
    '{16'd65535, 16'sd3217,   1'b0, 17'sd0, 17'sd0},
    '{16'd65535,-16'sd3216,   1'b0, 17'sd0, 17'sd0},
    '{16'd65535,-16'sd3217,   1'b0, 17'sd0, 17'sd0},
    '{16'd65535, 16'sd6433,   1'b0, 17'sd0, 17'sd0},
    '{16'd65535, 16'sd6434,   1'b0, 17'sd0, 17'sd0},
    '{16'd65535,-16'sd6433,   1'b0, 17'sd0, 17'sd0},
    '{16'd65535,-16'sd6434,   1'b0, 17'sd0, 17'sd0},
    '{16'd65535, 16'sd12867,  1'b0, 17'sd0, 17'sd0},
    '{16'd65535,-16'sd12868,  1'b0, 17'sd0, 17'sd0},
    '{16'd256,   16'sd1608,   1'b0, 17'sd0, 17'sd0},
    '{16'd256,   16'sd1,      1'b0, 17'sd0, 17'sd0},
    '{16'd256,  -16'sd1,      1'b0, 17'sd0, 17'sd0},
    '{16'd1,     16'sd9651,   1'b0, 17'sd0, 17'sd0},
    '{16'd43690, 16'sd10922,  1'b0, 17'sd0, 17'sd0},
    '{16'd21845,-16'sd10923,  1'b0, 17'sd0, 17'sd0},
    '{16'd65535, 16'sd19299,  1'b0, 17'sd0, 17'sd0},
    '{16'd32768,-16'sd16085,  1'b0, 17'sd0, 17'sd0}
  };

  polar_to_grid_offset dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .distance  (distance),
    .bearing   (bearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .grid_dx   (grid_dx),
    .grid_dy   (grid_dy)
  );

  always #1 clk = ~clk;

  // Shift right, rounding toward zero for negative values
  function automatic longint shift_toward_zero(input longint v, input int n);
    if (v >= 0) return v >>> n;
    return -((-v) >>> n);
  endfunction

  // Arctangent of 2^-i, Q30, truncated
  function automatic longint arctan_step(input int i);
    case (i)
      0:  return 843314856;
      1:  return 497837829;
      2:  return 263043836;
      3:  return 133525158;
      4:  return 67021686;
      5:  return 33543515;
      6:  return 16775850;
      7:  return 8388437;
      8:  return 4194282;
      9:  return 2097149;
      10: return 1048575;
      11: return 524287;
      12: return 262143;
      13: return 131071;
      14: return 65535;
      default: return 32767;
    endcase
  endfunction

  // Grid offset of one reading at the given scale
  function automatic grid_offset_t predict_grid_offset(input logic [15:0] span,
                                                       input logic signed [15:0] bear,
                                                       input logic [7:0] scale);
    longint ang, fold, cx, sy, z, step_x, step_y, nx, ny, scaled, xm, ym, sx, syy;
    bit top, right;
    grid_offset_t r;
    ang = longint'(bear) * 524288;
    // wrap once by 2*pi
    if (ang > AngPi) ang = ang - AngTwoPi;
    if (ang < -AngPi) ang = ang + AngTwoPi;
    // quadrant sets the signs
    if (ang > AngHalfPi) begin
      top = 1'b1; right = 1'b0;
    end else if (ang > 0) begin
      top = 1'b1; right = 1'b1;
    end else if (ang > -AngHalfPi) begin
      top = 1'b0; right = 1'b1;
    end else begin
      top = 1'b0; right = 1'b0;
    end
    // fold into [0, pi/2]
    fold = ang % AngPi;
    if (fold < 0) fold = fold + AngPi;
    if (fold > AngHalfPi) fold = AngPi - fold;
    // rotate from the gain-compensated unit vector
    cx = RotGain;
    sy = 0;
    z  = fold;
    for (int i = 0; i < 16; i++) begin
      step_x = shift_toward_zero(sy, i);
      step_y = shift_toward_zero(cx, i);
      if (z >= 0) begin
        cx = cx - step_x; sy = sy + step_y; z = z - arctan_step(i);
      end else begin
        cx = cx + step_x; sy = sy - step_y; z = z + arctan_step(i);
      end
    end
    // first-order correction with the leftover angle
    nx = cx - shift_toward_zero(sy * z, 30);
    ny = sy + shift_toward_zero(cx * z, 30);
    cx = (nx < 0) ? 0 : ((nx > UnitQ30) ? UnitQ30 : nx);
    sy = (ny < 0) ? 0 : ((ny > UnitQ30) ? UnitQ30 : ny);
    scaled = longint'(scale) * longint'(span);
    xm = (scaled * cx) >>> 38;
    ym = (scaled * sy) >>> 38;
    sx  = right ? xm : -xm;
    syy = top ? -ym : ym;
    r.dx = sx[16:0];
    r.dy = syy[16:0];
    return r;
  endfunction

  // Bias toward quadrant edges and the ends of the range
  function automatic logic signed [15:0] random_bearing();
    int pick, k, v, jitter;
    pick = $urandom_range(99);
    if (pick < 60) begin
      v = $urandom_range(38604);
      v = v - 19302;
    end else if (pick < 90) begin
      k = $urandom_range(12);
      k = k - 6;
      v = (k * 321699) / 100;
      jitter = $urandom_range(4);
      v = v + jitter - 2;
    end else begin
      jitter = $urandom_range(3);
      v = ($urandom_range(1) == 1) ? 19302 - jitter : jitter - 19302;
    end
    if (v > 19302) v = 19302;
    if (v < -19302) v = -19302;
    return v[15:0];
  endfunction

  function automatic logic [15:0] random_distance();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return 16'($urandom_range(3));
    if (pick < 20) return 16'(65532 + $urandom_range(3));
    if (pick < 35) return 16'($urandom_range(2048));
    return 16'($urandom_range(65535));
  endfunction

  // Offer one beat, optionally after an idle gap, and record its expected offset
  task automatic send_reading(input logic [15:0] span, input logic signed [15:0] bear,
                              input grid_offset_t want);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    distance <= span;
    bearing  <= bear;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_offsets.push_back(want);
    readings_sent++;
  endtask

  task automatic wait_drained();
    while (expected_offsets.size() != 0) @(posedge clk);
  endtask

  // Write the scale register while the block is idle
  task automatic write_scale(input logic [7:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    scale_setting = value;
  endtask

  task automatic run_phase(input logic [7:0] scale, input int send_idle,
                           input int recv_stall, input bit long_hold, input int count);
    logic [15:0]        span;
    logic signed [15:0] bear;
    write_scale(scale);
    sender_idle_pct    = send_idle;
    receiver_stall_pct = recv_stall;
    if (long_hold) hold_request = 1'b1;
    for (int n = 0; n < count; n++) begin
      span = random_distance();
      bear = random_bearing();
      send_reading(span, bear, predict_grid_offset(span, bear, scale_setting));
    end
    in_valid <= 1'b0;
    wait_drained();
  endtask

  // Output side: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_request && !hold_taken) begin
      hold_left  = HoldCycles;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Check each output beat against the oldest expected offset
  always @(posedge clk) begin : check_output
    grid_offset_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_offsets.size() == 0) begin
        $display("%0t: beat with nothing expected, actual dx=%0d dy=%0d",
                 $time, grid_dx, grid_dy);
        mismatch_count++;
      end else begin
        want = expected_offsets.pop_front();
        offsets_checked++;
        if (grid_dx !== want.dx) begin
          $display("%0t: grid_dx expected %0d actual %0d", $time, want.dx, grid_dx);
          mismatch_count++;
        end
        if (grid_dy !== want.dy) begin
          $display("%0t: grid_dy expected %0d actual %0d", $time, want.dy, grid_dy);
          mismatch_count++;
        end
      end
    end
  end

  // Hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout with %0d offsets outstanding", $time, expected_offsets.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    grid_offset_t want;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed rows at the reset scale
    for (int i = 0; i < NumDirected; i++) begin
      if (directed_rows[i].literal_known) begin
        want.dx = directed_rows[i].dx;
        want.dy = directed_rows[i].dy;
      end else begin
        want = predict_grid_offset(directed_rows[i].span, directed_rows[i].bear,
                                   scale_setting);
      end
      send_reading(directed_rows[i].span, directed_rows[i].bear, want);
    end
    in_valid <= 1'b0;
    wait_drained();

    // Random phases: scale extremes, zero scale, random scales, all idle patterns
    run_phase(8'd255, 0, 0, 1'b0, 250);
    run_phase(8'd1, 57, 0, 1'b0, 250);
    run_phase(8'd0, 0, 57, 1'b0, 40);
    run_phase(8'($urandom_range(2, 254)), 0, 57, 1'b0, 250);
    run_phase(8'($urandom_range(2, 254)), 16, 16, 1'b0, 250);
    run_phase(8'd255, 0, 0, 1'b1, 200);
    run_phase(8'($urandom_range(2, 254)), 0, 0, 1'b0, 210);

    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d readings and checked %0d offsets across scales 0, 1, 10, 255 and random,",
             readings_sent, offsets_checked);
    $display("with sender gaps, receiver stalls, both, none, and one long output hold-off.");
    if (mismatch_count == 0 && expected_offsets.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/p2g_pkg.sv
rtl/core/p2g_front.sv
rtl/core/p2g_queue.sv
rtl/core/p2g_back.sv
rtl/core/polar_to_grid_offset.sv
sim/tb_polar_to_grid_offset.sv
